/* src/dns_question_label_parser_assert.svh */
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef DNS_QUESTION_LABEL_PARSER_ASSERT_SVH
`define DNS_QUESTION_LABEL_PARSER_ASSERT_SVH

// Property holds at every edge.
`define DQLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define DQLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/dqlp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dqlp_pkg;

  localparam int unsigned MaxLabelsDefault   = 127;
  localparam int unsigned MaxLabelLenDefault = 63;
  localparam logic [3:0]  HeaderLengthReset  = 4'd12;
  localparam int unsigned QueueDepth         = 4;

  typedef enum logic [1:0] {
    KIND_CHAR      = 2'd0,
    KIND_DONE      = 2'd1,
    KIND_MALFORMED = 2'd2,
    KIND_TOO_MANY  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_HEADER  = 3'd1,
    PH_LENGTH  = 3'd2,
    PH_LABEL   = 3'd3,
    PH_TRAILER = 3'd4,
    PH_DISCARD = 3'd5
  } phase_e;

  // Compact result passed from parser to formatter.
  typedef struct packed {
    kind_e       kind;
    logic [6:0]  count;      // label index or label count
    logic [5:0]  pos;
    logic [7:0]  data;       // character, or low byte of the class
    logic        label_last;
    logic [23:0] trailer;    // type and high byte of the class
  } record_t;

endpackage

`default_nettype wire

/* src/dns_question_label_parser.sv */
// Accepts one message byte per cycle; push is held off only while the result queue is full.
// A result enters the queue as its byte is accepted, then the output register once free.
// Results leave at one per cycle while pop is high; a 4-entry queue and an output register
// decouple the sides. Reset clears parse state and queue and sets header_length to 12;
// bytes are ignored until the first message start.
`timescale 1ns / 1ps
`default_nettype none

module dns_question_label_parser import dqlp_pkg::*; #(
  parameter int unsigned MAX_LABELS    = MaxLabelsDefault,
  parameter int unsigned MAX_LABEL_LEN = MaxLabelLenDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [3:0]  cfg_data_i,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        message_start_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       kind_o,
  output logic [6:0]       label_index_o,
  output logic [5:0]       char_position_o,
  output logic [7:0]       char_value_o,
  output logic             label_last_o,
  output logic [6:0]       label_count_o,
  output logic [15:0]      query_type_o,
  output logic [15:0]      query_class_o,
  output logic             last_o
);

  logic    in_valid, res_valid, head_empty, head_rd;
  record_t res, head;

  assign in_valid = push && !full;

  dqlp_front #(
    .MAX_LABELS    (MAX_LABELS),
    .MAX_LABEL_LEN (MAX_LABEL_LEN)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid),
    .data_byte_i     (data_byte_i),
    .message_start_i (message_start_i),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  dqlp_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (res_valid),
    .wr_data_i (res),
    .full_o    (full),
    .rd_i      (head_rd),
    .rd_data_o (head),
    .empty_o   (head_empty)
  );

  dqlp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .head_empty_i    (head_empty),
    .head_rd_o       (head_rd),
    .empty           (empty),
    .pop             (pop),
    .kind_o          (kind_o),
    .label_index_o   (label_index_o),
    .char_position_o (char_position_o),
    .char_value_o    (char_value_o),
    .label_last_o    (label_last_o),
    .label_count_o   (label_count_o),
    .query_type_o    (query_type_o),
    .query_class_o   (query_class_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire

/* src/dqlp_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module dqlp_front import dqlp_pkg::*; #(
  parameter int unsigned MAX_LABELS    = MaxLabelsDefault,
  parameter int unsigned MAX_LABEL_LEN = MaxLabelLenDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [3:0] cfg_data_i,
  input  wire logic       in_valid_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       message_start_i,
  output logic            res_valid_o,
  output record_t         res_o
);

  localparam logic [7:0] MaxLen = 8'(MAX_LABEL_LEN);
  localparam logic [6:0] MaxLbl = 7'(MAX_LABELS);

  logic [3:0]  hdr_len_q;
  phase_e      phase_q, phase_d;
  logic [3:0]  hc_q, hc_d;
  logic [5:0]  rem_q, rem_d;
  logic [5:0]  cc_q, cc_d;
  logic [6:0]  lc_q, lc_d;
  logic [1:0]  tc_q, tc_d;
  logic [23:0] tb_q, tb_d;

  // State as seen by this byte: a message start restarts parsing on it.
  phase_e      ph_e;
  logic [3:0]  hc_e;
  logic [6:0]  lc_e;
  logic [1:0]  tc_e;
  logic [23:0] tb_e;
  logic        at_length, len_zero, len_bad, too_many;

  always_comb begin
    ph_e = message_start_i ? PH_HEADER : phase_q;
    hc_e = message_start_i ? hdr_len_q : hc_q;
    lc_e = message_start_i ? '0 : lc_q;
    tc_e = message_start_i ? '0 : tc_q;
    tb_e = message_start_i ? '0 : tb_q;
  end

  assign at_length = ((ph_e == PH_HEADER) && (hc_e == '0)) || (ph_e == PH_LENGTH);
  assign len_zero  = (data_byte_i == '0);
  assign len_bad   = (data_byte_i > MaxLen);
  assign too_many  = (lc_e >= MaxLbl);

  // Next state
  always_comb begin
    phase_d = phase_q;
    hc_d    = hc_q;
    rem_d   = rem_q;
    cc_d    = cc_q;
    lc_d    = lc_q;
    tc_d    = tc_q;
    tb_d    = tb_q;
    if (in_valid_i) begin
      phase_d = ph_e;
      hc_d    = hc_e;
      lc_d    = lc_e;
      tc_d    = tc_e;
      tb_d    = tb_e;
      if (at_length) begin
        if (len_zero) begin
          phase_d = PH_TRAILER;
          tc_d    = '0;
          tb_d    = '0;
        end else if (len_bad || too_many) begin
          phase_d = PH_DISCARD;
        end else begin
          rem_d   = data_byte_i[5:0];
          cc_d    = '0;
          phase_d = PH_LABEL;
        end
      end else begin
        unique case (ph_e)
          PH_HEADER: begin
            hc_d = hc_e - 4'd1;
            if (hc_e == 4'd1) phase_d = PH_LENGTH;
          end
          PH_LABEL: begin
            rem_d = rem_q - 6'd1;
            cc_d  = cc_q + 6'd1;
            if (rem_q == 6'd1) begin
              lc_d    = lc_e + 7'd1;
              phase_d = PH_LENGTH;
            end
          end
          PH_TRAILER: begin
            if (tc_e != 2'd3) begin
              tb_d = {tb_e[15:0], data_byte_i};
              tc_d = tc_e + 2'd1;
            end else begin
              tc_d    = '0;
              phase_d = PH_DISCARD;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Outputs
  always_comb begin
    res_valid_o      = 1'b0;
    res_o            = '0;
    res_o.kind       = KIND_CHAR;
    res_o.count      = lc_e;
    res_o.data       = data_byte_i;
    res_o.trailer    = tb_e;
    if (in_valid_i) begin
      if (at_length) begin
        if (!len_zero && (len_bad || too_many)) begin
          res_valid_o = 1'b1;
          res_o.kind  = len_bad ? KIND_MALFORMED : KIND_TOO_MANY;
        end
      end else if (ph_e == PH_LABEL) begin
        res_valid_o      = 1'b1;
        res_o.kind       = KIND_CHAR;
        res_o.pos        = cc_q;
        res_o.label_last = (rem_q == 6'd1);
      end else if ((ph_e == PH_TRAILER) && (tc_e == 2'd3)) begin
        res_valid_o = 1'b1;
        res_o.kind  = KIND_DONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_len_q <= HeaderLengthReset;
      phase_q   <= PH_IDLE;
      hc_q      <= '0;
      rem_q     <= '0;
      cc_q      <= '0;
      lc_q      <= '0;
      tc_q      <= '0;
      tb_q      <= '0;
    end else begin
      if (cfg_we_i) hdr_len_q <= cfg_data_i;
      phase_q <= phase_d;
      hc_q    <= hc_d;
      rem_q   <= rem_d;
      cc_q    <= cc_d;
      lc_q    <= lc_d;
      tc_q    <= tc_d;
      tb_q    <= tb_d;
    end
  end

endmodule

`default_nettype wire

/* src/dqlp_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module dqlp_queue import dqlp_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    wr_i,
  input  wire record_t wr_data_i,
  output logic         full_o,
  input  wire logic    rd_i,
  output record_t      rd_data_o,
  output logic         empty_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam logic [PtrW:0] DepthCnt = (PtrW + 1)'(QueueDepth);

  record_t           mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]     cnt_q, cnt_d;
  logic              do_wr, do_rd;

  assign full_o    = (cnt_q == DepthCnt);
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_wr && !do_rd) cnt_d = cnt_q + 1'b1;
    else if (!do_wr && do_rd) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_rd) rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_data_i;
  end

`include "dns_question_label_parser_assert.svh"

  `DQLP_ASSERT(a_cnt_bound, cnt_q <= DepthCnt, "queue count beyond depth")
  `DQLP_ASSERT(a_no_push_full, !(wr_i && full_o), "result pushed into full queue")
  `DQLP_ASSERT_NEXT(a_cnt_inc, do_wr && !do_rd, cnt_q == $past(cnt_q) + 1'b1, "count did not step")

endmodule

`default_nettype wire

/* src/dqlp_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module dqlp_back import dqlp_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire record_t head_i,
  input  wire logic    head_empty_i,
  output logic         head_rd_o,
  output logic         empty,
  input  wire logic    pop,
  output logic [1:0]   kind_o,
  output logic [6:0]   label_index_o,
  output logic [5:0]   char_position_o,
  output logic [7:0]   char_value_o,
  output logic         label_last_o,
  output logic [6:0]   label_count_o,
  output logic [15:0]  query_type_o,
  output logic [15:0]  query_class_o,
  output logic         last_o
);

  logic        valid_q;
  logic [1:0]  kind_q,  kind_d;
  logic [6:0]  idx_q,   idx_d;
  logic [5:0]  pos_q,   pos_d;
  logic [7:0]  chr_q,   chr_d;
  logic        llast_q, llast_d;
  logic [6:0]  cnt_q,   cnt_d;
  logic [15:0] qt_q,    qt_d;
  logic [15:0] qc_q,    qc_d;
  logic        last_q,  last_d;

  assign head_rd_o = !head_empty_i && (!valid_q || pop);

  // Expand the record; fields that do not apply to a kind read as zero.
  always_comb begin
    kind_d  = head_i.kind;
    idx_d   = '0;
    pos_d   = '0;
    chr_d   = '0;
    llast_d = 1'b0;
    cnt_d   = '0;
    qt_d    = '0;
    qc_d    = '0;
    last_d  = 1'b0;
    unique case (head_i.kind)
      KIND_CHAR: begin
        idx_d   = head_i.count;
        pos_d   = head_i.pos;
        chr_d   = head_i.data;
        llast_d = head_i.label_last;
      end
      KIND_DONE: begin
        cnt_d  = head_i.count;
        qt_d   = head_i.trailer[23:8];
        qc_d   = {head_i.trailer[7:0], head_i.data};
        last_d = 1'b1;
      end
      default: begin
        cnt_d  = head_i.count;
        last_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (head_rd_o) begin
      valid_q <= 1'b1;
    end else if (pop) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_rd_o) begin
      kind_q  <= kind_d;
      idx_q   <= idx_d;
      pos_q   <= pos_d;
      chr_q   <= chr_d;
      llast_q <= llast_d;
      cnt_q   <= cnt_d;
      qt_q    <= qt_d;
      qc_q    <= qc_d;
      last_q  <= last_d;
    end
  end

  assign empty           = !valid_q;
  assign kind_o          = kind_q;
  assign label_index_o   = idx_q;
  assign char_position_o = pos_q;
  assign char_value_o    = chr_q;
  assign label_last_o    = llast_q;
  assign label_count_o   = cnt_q;
  assign query_type_o    = qt_q;
  assign query_class_o   = qc_q;
  assign last_o          = last_q;

endmodule

`default_nettype wire

/* dv/tb_dns_question_label_parser.sv */
`timescale 1ns / 1ps

module tb_dns_question_label_parser;
  import dqlp_pkg::*;

  localparam int CycleLimit = 600_000;
  localparam int ItemTarget = 1850;

  typedef struct packed {
    kind_e       kind;
    logic [6:0]  label_index;
    logic [5:0]  char_position;
    logic [7:0]  char_value;
    logic        label_last;
    logic [6:0]  label_count;
    logic [15:0] query_type;
    logic [15:0] query_class;
    logic        last;
  } name_res_t;

  typedef struct packed {
    logic [7:0] data;
    logic       st;
    logic       typed;
    name_res_t  want;
  } dir_row_t;

  localparam name_res_t NoRes = '0;

  // Header length 0 throughout. Typed rows carry their result; the rest are predicted.
  localparam dir_row_t DirTab [24] = '{
    '{8'h41, 1'b0, 1'b0, NoRes},   // before any message start: ignored
    '{8'h00, 1'b1, 1'b0, NoRes},   // empty name, start byte is the length byte
    '{8'hFF, 1'b0, 1'b0, NoRes},
    '{8'hFF, 1'b0, 1'b0, NoRes},
    '{8'hFF, 1'b0, 1'b0, NoRes},
    '{8'hFF, 1'b0, 1'b1,
      '{KIND_DONE, 7'd0, 6'd0, 8'd0, 1'b0, 7'd0, 16'hFFFF, 16'hFFFF, 1'b1}},
    '{8'h07, 1'b0, 1'b0, NoRes},   // after question end: ignored
    '{8'h40, 1'b1, 1'b1,
      '{KIND_MALFORMED, 7'd0, 6'd0, 8'd0, 1'b0, 7'd0, 16'h0, 16'h0, 1'b1}},
    '{8'h01, 1'b1, 1'b0, NoRes},
    '{8'hFF, 1'b0, 1'b1,
      '{KIND_CHAR, 7'd0, 6'd0, 8'hFF, 1'b1, 7'd0, 16'h0, 16'h0, 1'b0}},
    '{8'h02, 1'b0, 1'b0, NoRes},
    '{8'h00, 1'b0, 1'b0, NoRes},
    '{8'h80, 1'b0, 1'b0, NoRes},
    '{8'hFF, 1'b0, 1'b1,
      '{KIND_MALFORMED, 7'd0, 6'd0, 8'd0, 1'b0, 7'd2, 16'h0, 16'h0, 1'b1}},
    '{8'h03, 1'b1, 1'b0, NoRes},
    '{8'h61, 1'b0, 1'b0, NoRes},
    '{8'h02, 1'b1, 1'b0, NoRes},   // restart mid-label
    '{8'h62, 1'b0, 1'b0, NoRes},
    '{8'h63, 1'b0, 1'b0, NoRes},
    '{8'h00, 1'b0, 1'b0, NoRes},
    '{8'h00, 1'b0, 1'b0, NoRes},
    '{8'h01, 1'b0, 1'b0, NoRes},
    '{8'h00, 1'b0, 1'b0, NoRes},
    '{8'h01, 1'b0, 1'b1,
      '{KIND_DONE, 7'd0, 6'd0, 8'd0, 1'b0, 7'd1, 16'h0001, 16'h0001, 1'b1}}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [3:0]  cfg_data_i = '0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte_i = '0;
  logic        message_start_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  kind_o;
  logic [6:0]  label_index_o;
  logic [5:0]  char_position_o;
  logic [7:0]  char_value_o;
  logic        label_last_o;
  logic [6:0]  label_count_o;
  logic [15:0] query_type_o;
  logic [15:0] query_class_o;
  logic        last_o;

  dns_question_label_parser dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .push            (push),
    .full            (full),
    .data_byte_i     (data_byte_i),
    .message_start_i (message_start_i),
    .empty           (empty),
    .pop             (pop),
    .kind_o          (kind_o),
    .label_index_o   (label_index_o),
    .char_position_o (char_position_o),
    .char_value_o    (char_value_o),
    .label_last_o    (label_last_o),
    .label_count_o   (label_count_o),
    .query_type_o    (query_type_o),
    .query_class_o   (query_class_o),
    .last_o          (last_o)
  );

  always #5 clk_i = ~clk_i;

  // Parser shadow state
  logic [3:0]  hdr_len = HeaderLengthReset;
  phase_e      p_phase = PH_IDLE;
  logic [3:0]  p_hdr_left = '0;
  logic [5:0]  p_lbl_left = '0;
  logic [5:0]  p_char_cnt = '0;
  logic [6:0]  p_lbl_cnt = '0;
  logic [1:0]  p_trl_cnt = '0;
  logic [23:0] p_trl = '0;

  name_res_t   want_q[$];
  int          n_err = 0;
  int          n_sent = 0;
  int          n_cyc = 0;
  int          snd_max = 0;
  int          rcv_max = 0;
  int          rx_hold = 0;
  bit          pushing = 1'b0;

  function automatic bit take_length(input logic [7:0] b, output name_res_t r);
    r = '0;
    if (b == 8'd0) begin
      p_phase   = PH_TRAILER;
      p_trl_cnt = '0;
      p_trl     = '0;
      return 1'b0;
    end
    if (b > MaxLabelLenDefault) begin
      r.kind        = KIND_MALFORMED;
      r.label_count = p_lbl_cnt;
      r.last        = 1'b1;
      p_phase       = PH_DISCARD;
      return 1'b1;
    end
    if (p_lbl_cnt >= MaxLabelsDefault) begin
      r.kind        = KIND_TOO_MANY;
      r.label_count = p_lbl_cnt;
      r.last        = 1'b1;
      p_phase       = PH_DISCARD;
      return 1'b1;
    end
    p_lbl_left = b[5:0];
    p_char_cnt = '0;
    p_phase    = PH_LABEL;
    return 1'b0;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, input logic st, output name_res_t r);
    r = '0;
    if (st) begin
      p_phase    = PH_HEADER;
      p_hdr_left = hdr_len;
      p_lbl_left = '0;
      p_char_cnt = '0;
      p_lbl_cnt  = '0;
      p_trl_cnt  = '0;
      p_trl      = '0;
    end
    case (p_phase)
      PH_HEADER: begin
        if (p_hdr_left == '0) return take_length(b, r);
        p_hdr_left--;
        if (p_hdr_left == '0) p_phase = PH_LENGTH;
        return 1'b0;
      end
      PH_LENGTH: return take_length(b, r);
      PH_LABEL: begin
        r.kind          = KIND_CHAR;
        r.label_index   = p_lbl_cnt;
        r.char_position = p_char_cnt;
        r.char_value    = b;
        r.label_last    = (p_lbl_left == 6'd1);
        p_lbl_left--;
        p_char_cnt++;
        if (p_lbl_left == '0) begin
          p_lbl_cnt++;
          p_phase = PH_LENGTH;
        end
        return 1'b1;
      end
      PH_TRAILER: begin
        if (p_trl_cnt < 2'd3) begin
          p_trl = {p_trl[15:0], b};
          p_trl_cnt++;
          return 1'b0;
        end
        r.kind        = KIND_DONE;
        r.label_count = p_lbl_cnt;
        r.query_type  = p_trl[23:8];
        r.query_class = {p_trl[7:0], b};
        r.last        = 1'b1;
        p_trl_cnt     = '0;
        p_phase       = PH_DISCARD;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic int gap_ceiling();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 4;
      default: return 17;
    endcase
  endfunction

  task automatic report(input string what, input name_res_t w, input name_res_t g);
    n_err++;
    if (n_err <= 10) begin
      $display("%s at %0t: want k=%0d i=%0d p=%0d c=%02h ll=%0b n=%0d t=%04h q=%04h l=%0b",
               what, $realtime, w.kind, w.label_index, w.char_position, w.char_value,
               w.label_last, w.label_count, w.query_type, w.query_class, w.last);
      $display("  got k=%0d i=%0d p=%0d c=%02h ll=%0b n=%0d t=%04h q=%04h l=%0b",
               g.kind, g.label_index, g.char_position, g.char_value,
               g.label_last, g.label_count, g.query_type, g.query_class, g.last);
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic st, input logic typed,
                           input name_res_t fixed);
    int        gap;
    bit        got;
    name_res_t r;
    gap = $urandom_range(0, snd_max);
    if (gap != 0) begin
      if (pushing) begin
        push <= 1'b0;
        pushing = 1'b0;
      end
      repeat (gap) @(posedge clk_i);
    end
    push            <= 1'b1;
    pushing          = 1'b1;
    data_byte_i     <= b;
    message_start_i <= st;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    got = parse_byte(b, st, r);
    if (typed) want_q.push_back(fixed);
    else if (got) want_q.push_back(r);
    n_sent++;
  endtask

  task automatic write_hdr(input logic [3:0] v);
    if (pushing) begin
      push <= 1'b0;
      pushing = 1'b0;
    end
    while (want_q.size() != 0) @(posedge clk_i);
    // bytes that give no result may still be in the pipeline
    repeat (6) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    hdr_len   = v;
  endtask

  // clean: no malformed ending, no truncation, no noise
  task automatic send_msg(input int nlab, input int maxlen, input bit clean);
    logic [7:0] mb[$];
    int         len, k, j, cut, pick;
    pick = clean ? 99 : $urandom_range(0, 99);
    if (pick < 6) begin
      len = $urandom_range(1, 24);
      for (k = 0; k < len; k++) mb.push_back(8'($urandom_range(0, 255)));
    end else begin
      for (k = 0; k < hdr_len; k++) mb.push_back(8'($urandom_range(0, 255)));
      for (k = 0; k < nlab; k++) begin
        case ($urandom_range(0, 19))
          0: len = (maxlen > 8) ? 63 : 1;
          1: len = 1;
          default: len = $urandom_range(1, maxlen);
        endcase
        mb.push_back(8'(len));
        for (j = 0; j < len; j++) mb.push_back(8'($urandom_range(0, 255)));
      end
      if (pick < 16) begin
        mb.push_back(8'($urandom_range(64, 255)));
      end else begin
        mb.push_back(8'h00);
        for (k = 0; k < 4; k++) mb.push_back(8'($urandom_range(0, 255)));
      end
      len = $urandom_range(0, 3);
      for (k = 0; k < len; k++) mb.push_back(8'($urandom_range(0, 255)));
      if (!clean && $urandom_range(0, 99) < 12) begin
        cut = $urandom_range(1, mb.size());
        while (mb.size() > cut) void'(mb.pop_back());
      end
    end
    for (k = 0; k < mb.size(); k++) send_byte(mb[k], k == 0, 1'b0, NoRes);
  endtask

  initial begin : watchdog
    while (n_cyc < CycleLimit) begin
      @(posedge clk_i);
      n_cyc++;
    end
    $display("tb_dns_question_label_parser: errors");
    $finish;
  end

  initial begin : result_sink
    int        gap, n;
    name_res_t g, w;
    @(posedge rst_ni);
    forever begin
      if (rx_hold != 0) begin
        gap     = rx_hold;
        rx_hold = 0;
      end else begin
        gap = $urandom_range(0, rcv_max);
      end
      if (gap != 0) begin
        pop <= 1'b0;
        for (n = 0; n < gap; n++) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      g = '{kind_e'(kind_o), label_index_o, char_position_o, char_value_o, label_last_o,
            label_count_o, query_type_o, query_class_o, last_o};
      if (want_q.size() == 0) begin
        report("unexpected item", NoRes, g);
      end else begin
        w = want_q.pop_front();
        if (g.kind !== w.kind || g.label_index !== w.label_index ||
            g.char_position !== w.char_position || g.char_value !== w.char_value ||
            g.label_last !== w.label_last || g.label_count !== w.label_count ||
            g.query_type !== w.query_type || g.query_class !== w.query_class ||
            g.last !== w.last)
          report("mismatch", w, g);
      end
    end
  end

  initial begin : stimulus
    int          ph, k;
    logic [3:0]  hv;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_hdr(4'd0);
    snd_max = 3;
    rcv_max = 3;
    for (k = 0; k < 24; k++)
      send_byte(DirTab[k].data, DirTab[k].st, DirTab[k].typed, DirTab[k].want);

    ph = 0;
    while (n_sent < ItemTarget) begin
      case (ph % 4)
        0: hv = HeaderLengthReset;
        1: hv = 4'd0;
        2: hv = 4'd15;
        default: hv = 4'($urandom_range(0, 15));
      endcase
      write_hdr(hv);
      snd_max = gap_ceiling();
      rcv_max = gap_ceiling();
      if (ph == 2) begin
        // long receiver stall with the sender flat out: the block must back up
        snd_max = 0;
        rx_hold = 150;
      end
      // 126, 127 and 128 labels: up to and beyond the label limit
      if (ph >= 1 && ph <= 3) send_msg(125 + ph, 1, 1'b1);
      repeat (6) send_msg($urandom_range(0, 6), 8, 1'b0);
      ph++;
    end

    push <= 1'b0;
    while (want_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (n_err == 0 && want_q.size() == 0)
      $display("tb_dns_question_label_parser: clean");
    else
      $display("tb_dns_question_label_parser: errors");
    $finish;
  end

endmodule
